### src/resizable_array_block_manager_unit_defines.svh
// Assertion macros used by the block manager datapath.
`ifndef RESIZABLE_ARRAY_BLOCK_MANAGER_UNIT_DEFINES_SVH
`define RESIZABLE_ARRAY_BLOCK_MANAGER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RABM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RABM_ASSERT_NEXT(lbl, ante, cons, msg) \
	`RABM_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define RABM_ASSERT(lbl, prop, msg)
`define RABM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/rabm_pkg.sv
package rabm_pkg;

	localparam int INDEX_BITS = 24;
	localparam int COUNT_W    = INDEX_BITS + 1;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int BLOCK_W    = 14;
	localparam int OFFSET_W   = 12;
	localparam int SIZE_W     = 13;
	localparam int SB_NUM_W   = 5;
	localparam int POS_W      = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 96;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(1) << INDEX_BITS;

	localparam logic [CMD_W-1:0] CMD_GROW   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SHRINK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

endpackage

### src/rabm_ctrl.sv
module rabm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                m_tready,
	input  rabm_pkg::dp_stat_t  stat,
	output rabm_pkg::ctrl_cmd_t cmd
);
	import rabm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   load_ok;

	assign load_ok     = !stat.out_full || m_tready;
	assign s_tready    = (state_q == S_IDLE);
	assign cmd.capture = s_tvalid && s_tready;
	assign cmd.exec    = (state_q == S_CALC);
	assign cmd.load    = (state_q == S_FINISH) && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/rabm_dp.sv
`include "resizable_array_block_manager_unit_defines.svh"

module rabm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rabm_pkg::ctrl_cmd_t                 cmd,
	output rabm_pkg::dp_stat_t                  stat,
	input  logic [rabm_pkg::CMD_W-1:0]          in_command,
	input  logic [rabm_pkg::INDEX_BITS-1:0]     in_index,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rabm_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [rabm_pkg::STATUS_W-1:0]       m_tuser
);
	import rabm_pkg::*;

	logic [CMD_W-1:0]      cmd_q;
	logic [INDEX_BITS-1:0] idx_q;

	logic [COUNT_W-1:0]  total_q;
	logic [BLOCK_W-1:0]  cb_q;
	logic [SIZE_W-1:0]   fill_q;
	logic [SIZE_W-1:0]   bcap_q;
	logic [SIZE_W-1:0]   sbf_q;
	logic [SIZE_W-1:0]   sbcap_q;
	logic [SB_NUM_W-1:0] sbn_q;
	logic [BLOCK_W-1:0]  alloc_q;

	logic [COUNT_W-1:0]  n_total;
	logic [BLOCK_W-1:0]  n_cb;
	logic [SIZE_W-1:0]   n_fill;
	logic [SIZE_W-1:0]   n_bcap;
	logic [SIZE_W-1:0]   n_sbf;
	logic [SIZE_W-1:0]   n_sbcap;
	logic [SB_NUM_W-1:0] n_sbn;
	logic [BLOCK_W-1:0]  n_alloc;

	logic [STATUS_W-1:0] n_status;
	logic                n_av;
	logic [BLOCK_W-1:0]  n_ab;
	logic [SIZE_W-1:0]   n_as;
	logic                n_fv;
	logic [BLOCK_W-1:0]  n_fb;
	logic [COUNT_W-1:0]  n_r;
	logic [POS_W-1:0]    n_k;

	logic [STATUS_W-1:0] res_status_q;
	logic                res_av_q;
	logic [BLOCK_W-1:0]  res_ab_q;
	logic [SIZE_W-1:0]   res_as_q;
	logic                res_fv_q;
	logic [BLOCK_W-1:0]  res_fb_q;
	logic [COUNT_W-1:0]  r_q;
	logic [POS_W-1:0]    k_q;

	logic [POS_W-1:0]    hi;
	logic [POS_W-1:0]    lo_unused_free;
	logic [COUNT_W-1:0]  one_hi;
	logic [COUNT_W-1:0]  loc_block;
	logic [COUNT_W-1:0]  loc_offset;
	logic                loc_hit;

	logic                out_valid_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [BLOCK_W-1:0]  o_block_q;
	logic [OFFSET_W-1:0] o_offset_q;
	logic [COUNT_W-1:0]  o_count_q;
	logic                o_av_q;
	logic [BLOCK_W-1:0]  o_ab_q;
	logic [SIZE_W-1:0]   o_as_q;
	logic                o_fv_q;
	logic [BLOCK_W-1:0]  o_fb_q;

	always_comb begin
		n_total  = total_q;
		n_cb     = cb_q;
		n_fill   = fill_q;
		n_bcap   = bcap_q;
		n_sbf    = sbf_q;
		n_sbcap  = sbcap_q;
		n_sbn    = sbn_q;
		n_alloc  = alloc_q;
		n_status = ST_OK;
		n_av     = 1'b0;
		n_ab     = '0;
		n_as     = '0;
		n_fv     = 1'b0;
		n_fb     = '0;
		unique case (cmd_q)
			CMD_GROW: begin
				if (total_q >= FULL_COUNT) begin
					n_status = ST_FULL;
				end else begin
					if (fill_q >= bcap_q) begin
						if (sbf_q >= sbcap_q) begin
							n_sbn = sbn_q + SB_NUM_W'(1);
							if (n_sbn[0]) begin
								n_bcap = {bcap_q[SIZE_W-2:0], 1'b0};
							end else begin
								n_sbcap = {sbcap_q[SIZE_W-2:0], 1'b0};
							end
							n_sbf = '0;
						end
						if ({1'b0, alloc_q} == {1'b0, cb_q} + (BLOCK_W+1)'(1)) begin
							n_av    = 1'b1;
							n_ab    = cb_q + BLOCK_W'(1);
							n_as    = n_bcap;
							n_alloc = alloc_q + BLOCK_W'(1);
						end
						n_cb   = cb_q + BLOCK_W'(1);
						n_sbf  = n_sbf + SIZE_W'(1);
						n_fill = '0;
					end
					n_total = total_q + COUNT_W'(1);
					n_fill  = n_fill + SIZE_W'(1);
				end
			end
			CMD_SHRINK: begin
				if (total_q == '0) begin
					n_status = ST_EMPTY;
				end else begin
					n_total = total_q - COUNT_W'(1);
					if (fill_q != '0) begin
						n_fill = fill_q - SIZE_W'(1);
					end
					if (n_fill == '0) begin
						if ({1'b0, alloc_q} == {1'b0, cb_q} + (BLOCK_W+1)'(2)) begin
							n_fv    = 1'b1;
							n_fb    = cb_q + BLOCK_W'(1);
							n_alloc = alloc_q - BLOCK_W'(1);
						end
						if (cb_q != '0) begin
							n_cb = cb_q - BLOCK_W'(1);
							if (sbf_q != '0) begin
								n_sbf = sbf_q - SIZE_W'(1);
							end
							if (n_sbf == '0 && sbn_q != '0) begin
								// Undo the doubling made when the superblock was entered.
								if (sbn_q[0]) begin
									if (bcap_q > SIZE_W'(1)) begin
										n_bcap = bcap_q >> 1;
									end
								end else begin
									if (sbcap_q > SIZE_W'(1)) begin
										n_sbcap = sbcap_q >> 1;
									end
								end
								n_sbn = sbn_q - SB_NUM_W'(1);
								n_sbf = n_sbcap;
							end
							n_fill = n_bcap;
						end
					end
				end
			end
			CMD_LOCATE: begin
				if ({1'b0, idx_q} >= total_q) begin
					n_status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		n_r = {1'b0, idx_q} + COUNT_W'(1);
		n_k = '0;
		for (int b = 0; b < COUNT_W; b++) begin
			if (n_r[b]) begin
				n_k = POS_W'(b);
			end
		end
	end

	// Block number is (r >> hi) + 2^hi - 2, offset is the low hi bits of r.
	assign hi             = (k_q + POS_W'(1)) >> 1;
	assign lo_unused_free = '0;
	assign one_hi         = COUNT_W'(1) << hi;
	assign loc_block      = (r_q >> hi) + one_hi - COUNT_W'(2) + COUNT_W'(lo_unused_free);
	assign loc_offset     = r_q & (one_hi - COUNT_W'(1));
	assign loc_hit        = (cmd_q == CMD_LOCATE) && (res_status_q == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			cb_q    <= '0;
			fill_q  <= '0;
			bcap_q  <= SIZE_W'(1);
			sbf_q   <= SIZE_W'(1);
			sbcap_q <= SIZE_W'(1);
			sbn_q   <= '0;
			alloc_q <= BLOCK_W'(1);
		end else if (cmd.exec) begin
			total_q <= n_total;
			cb_q    <= n_cb;
			fill_q  <= n_fill;
			bcap_q  <= n_bcap;
			sbf_q   <= n_sbf;
			sbcap_q <= n_sbcap;
			sbn_q   <= n_sbn;
			alloc_q <= n_alloc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_command;
			idx_q <= in_index;
		end
		if (cmd.exec) begin
			res_status_q <= n_status;
			res_av_q     <= n_av;
			res_ab_q     <= n_ab;
			res_as_q     <= n_as;
			res_fv_q     <= n_fv;
			res_fb_q     <= n_fb;
			r_q          <= n_r;
			k_q          <= n_k;
		end
		if (cmd.load) begin
			o_status_q <= res_status_q;
			o_block_q  <= loc_hit ? loc_block[BLOCK_W-1:0] : '0;
			o_offset_q <= loc_hit ? loc_offset[OFFSET_W-1:0] : '0;
			o_count_q  <= total_q;
			o_av_q     <= res_av_q;
			o_ab_q     <= res_ab_q;
			o_as_q     <= res_as_q;
			o_fv_q     <= res_fv_q;
			o_fb_q     <= res_fb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_full = out_valid_q;
	assign m_tvalid      = out_valid_q;
	assign m_tuser       = o_status_q;
	assign m_tdata       = {2'b00, o_fb_q, o_fv_q, o_as_q, o_ab_q, o_av_q,
		o_count_q, o_offset_q, o_block_q};

	`RABM_ASSERT(a_spare_block, (alloc_q == cb_q + BLOCK_W'(1)) || (alloc_q == cb_q + BLOCK_W'(2)), "allocated block count lost track of the current block")
	`RABM_ASSERT(a_fill_bound, fill_q <= bcap_q, "current block fill exceeds its capacity")
	`RABM_ASSERT_NEXT(a_load_shows, cmd.load, out_valid_q, "loaded result is not presented")

endmodule

### src/resizable_array_block_manager_unit.sv
// Channel  Direction  Transfer contents
// s_*      in         tuser[1:0] command; tdata[23:0] element_index
// m_*      out        tuser[1:0] status; tdata block number, offset, count, alloc, free
//
// A command passes through three steps: accept, state update with leading-one detect,
// then address computation and load of the output register.
// A new command is accepted only after the previous one has loaded the output register.
// Asynchronous reset leaves an empty array with block zero preallocated.
// The final cycle holds while the output register is full and not taken.
module resizable_array_block_manager_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [23:0] element_index
	input  logic [rabm_pkg::IN_DATA_W-1:0]      s_tdata,
	// [1:0] command
	input  logic [rabm_pkg::CMD_W-1:0]          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [13:0] block_number, [25:14] block_offset, [50:26] element_count,
	// [51] alloc_valid, [65:52] alloc_block, [78:66] alloc_size,
	// [79] free_valid, [93:80] free_block, [95:94] zero
	output logic [rabm_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [1:0] status
	output logic [rabm_pkg::STATUS_W-1:0]       m_tuser
);
	import rabm_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	rabm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (ctl)
	);

	rabm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl),
		.stat       (stat),
		.in_command (s_tuser),
		.in_index   (s_tdata[INDEX_BITS-1:0]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule
